@@ rtl/core/ppt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polled point table package
// Field widths, request and area codes, the stored entry layout, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int KIND_W = 1;
    localparam int AREA_W = 2;
    localparam int ADDR_W = 16;
    localparam int VAL_W  = 32;
    localparam int KEY_W  = AREA_W + ADDR_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_UPDATE   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RETRIEVE = 1'b1;

    // Areas. Coils and discrete inputs lie below the first register area.
    localparam logic [AREA_W-1:0] AREA_COIL           = 2'd0;
    localparam logic [AREA_W-1:0] AREA_DISCRETE_INPUT = 2'd1;
    localparam logic [AREA_W-1:0] AREA_INPUT_REG      = 2'd2;
    localparam logic [AREA_W-1:0] AREA_HOLDING_REG    = 2'd3;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic                    good;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/ppt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polled point table controller
// Sequences one request at a time: capture, key scan, commit of the result.
// ----------------------------------------------------------------------------
module ppt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ppt_pkg::t_dp_sts  i_sts,
    output ppt_pkg::t_dp_cmd  o_cmd
);
    import ppt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   w_accept;

    // A new request is taken only when the previous one has been committed.
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        o_cmd.load   = w_accept;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_sts.done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/ppt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polled point table datapath
// Request register, entry memory with key scan, fill count and result register.
// ----------------------------------------------------------------------------
module ppt_dp #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppt_pkg::t_dp_cmd                 i_cmd,
    output ppt_pkg::t_dp_sts                 o_sts,
    input  logic [ppt_pkg::KIND_W-1:0]       i_kind,
    input  logic [ppt_pkg::AREA_W-1:0]       i_area,
    input  logic [ppt_pkg::ADDR_W-1:0]       i_point_address,
    input  logic signed [ppt_pkg::VAL_W-1:0] i_new_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [ppt_pkg::ADDR_W-1:0]       o_echo_address,
    output logic signed [ppt_pkg::VAL_W-1:0] o_read_value,
    output logic                             o_point_good,
    output logic                             o_status
);
    import ppt_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);

    // Request register.
    logic [KIND_W-1:0]       r_kind;
    logic [AREA_W-1:0]       r_area;
    logic [ADDR_W-1:0]       r_addr;
    logic signed [VAL_W-1:0] r_value;

    // Entry memory and its registered read port.
    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rdata;

    // Scan state.
    logic [CNT_W-1:0]        r_scan_idx;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pend_idx;
    logic                    r_hit;
    logic [IDX_W-1:0]        r_hit_idx;
    logic                    r_hit_good;
    logic signed [VAL_W-1:0] r_hit_value;
    logic [CNT_W-1:0]        r_fill;

    // Result register.
    logic                    r_out_valid;
    logic [ADDR_W-1:0]       r_out_addr;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_good;
    logic                    r_out_status;

    logic [KEY_W-1:0]        w_key;
    logic                    w_bit_area;
    logic                    w_store_good;
    logic signed [VAL_W-1:0] w_store_value;
    logic                    w_full;
    logic                    w_more;
    logic                    w_match;
    logic                    w_rd_en;
    logic                    w_wr_en;
    logic [IDX_W-1:0]        w_wr_addr;
    t_entry                  w_wr_entry;

    assign w_key      = {r_area, r_addr};
    assign w_bit_area = (r_area < AREA_INPUT_REG);

    // Bit areas keep only 0 and 1; register areas mark all ones as bad.
    always_comb begin
        if (w_bit_area) begin
            w_store_good  = (r_value == VAL_W'(0)) || (r_value == VAL_W'(1));
            w_store_value = w_store_good ? r_value : '0;
        end else begin
            w_store_good  = (r_value != {VAL_W{1'b1}});
            w_store_value = r_value;
        end
    end

    assign w_full    = (r_fill == SLOTS_C);
    assign w_more    = (r_scan_idx < r_fill);
    assign w_match   = r_pend && (r_rdata.key == w_key);
    assign w_rd_en   = i_cmd.scan && !r_hit && w_more;
    assign w_wr_en   = i_cmd.commit && (r_kind == KIND_UPDATE) && (r_hit || !w_full);
    assign w_wr_addr = r_hit ? r_hit_idx : r_fill[IDX_W-1:0];

    always_comb begin
        w_wr_entry.key   = w_key;
        w_wr_entry.good  = w_store_good;
        w_wr_entry.value = w_store_value;
    end

    assign o_sts.done     = r_hit || (!r_pend && !w_more);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_entry;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_scan_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx  <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_pend     <= 1'b0;
                r_hit      <= 1'b0;
            end else if (i_cmd.scan && !r_hit) begin
                r_pend <= w_more;
                if (w_more) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (w_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (w_wr_en && !r_hit) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_area  <= i_area;
            r_addr  <= i_point_address;
            r_value <= i_new_value;
        end
        if (w_rd_en) begin
            r_pend_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (i_cmd.scan && !r_hit && w_match) begin
            r_hit_idx   <= r_pend_idx;
            r_hit_good  <= r_rdata.good;
            r_hit_value <= r_rdata.value;
        end
        if (i_cmd.commit) begin
            r_out_addr <= r_addr;
            if (r_kind == KIND_RETRIEVE) begin
                r_out_value  <= r_hit ? r_hit_value : '0;
                r_out_good   <= r_hit && r_hit_good;
                r_out_status <= STATUS_OK;
            end else begin
                r_out_value  <= '0;
                r_out_good   <= (r_hit || !w_full) && w_store_good;
                r_out_status <= (!r_hit && w_full) ? STATUS_OOM : STATUS_OK;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_echo_address = r_out_addr;
    assign o_read_value   = r_out_value;
    assign o_point_good   = r_out_good;
    assign o_status       = r_out_status;

    // The fill count never runs past the table size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SLOTS_C)
        else $error("fill count exceeds table size");

    // A found entry always lies among the slots in use.
    a_hit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (CNT_W'(r_hit_idx) < r_fill))
        else $error("hit index outside filled slots");

    // The fill count moves only on a committed update.
    a_fill_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> $past(i_cmd.commit && (r_kind == KIND_UPDATE)))
        else $error("fill count changed without a committed update");

    // A commit always presents a result in the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

    // A result held under stall is not overwritten by a commit.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.commit)
        else $error("result overwritten while stalled");

endmodule

@@ rtl/core/polled_point_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polled point table
// Key/value table of polled Modbus points keyed by area and point address,
// with insert-or-update and retrieve requests.
// ----------------------------------------------------------------------------
//
//  Channel   Valid     Stall     Payload
//  request   i_valid   o_stall   i_kind, i_area, i_point_address, i_new_value
//  result    o_valid   i_stall   o_echo_address, o_read_value, o_point_good,
//                                o_status
//
// A transfer happens on a rising edge where valid is high and stall is low.
// Each request scans the slots in use until it finds a match: the scan
// reads one slot of the entry memory per cycle through its single read port,
// and slots in use always form a prefix of the table.
// The result waits in an output register, so the next request is taken and
// scanned while a stalled result is still held; a commit waits for it to leave.
// Reset is synchronous and active low. It empties the table by clearing the
// fill count; no clearing pass runs, so the block is ready right after reset.
//
// An update overwrites the matching entry or appends one at the fill count.
// Coils and discrete inputs store 0 and 1 as good, anything else as 0 and not
// good. Register areas store the value as given, good unless it is all ones.
// An append into a full table stores nothing and reports out of memory.
// A retrieve returns the stored value and mark, or 0 and not good if absent.
// ----------------------------------------------------------------------------
module polled_point_table #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ppt_pkg::KIND_W-1:0]       i_kind,
    input  logic [ppt_pkg::AREA_W-1:0]       i_area,
    input  logic [ppt_pkg::ADDR_W-1:0]       i_point_address,
    input  logic signed [ppt_pkg::VAL_W-1:0] i_new_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ppt_pkg::ADDR_W-1:0]       o_echo_address,
    output logic signed [ppt_pkg::VAL_W-1:0] o_read_value,
    output logic                             o_point_good,
    output logic                             o_status
);
    import ppt_pkg::*;

    // Commands flow from the controller, status flows back.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller owns the request handshake and the step sequence.
    ppt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the table, the scan and the result register.
    ppt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_area          (i_area),
        .i_point_address (i_point_address),
        .i_new_value     (i_new_value),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_echo_address  (o_echo_address),
        .o_read_value    (o_read_value),
        .o_point_good    (o_point_good),
        .o_status        (o_status)
    );

endmodule

@@ tb/polled_point_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polled point table testbench
// Drives update and retrieve requests into the point table and compares
// every result against a shadow copy of the table kept in a scoreboard
// class. It runs a directed opening, then random traffic under three
// idling patterns, including one long hold-off on the result side.
// ----------------------------------------------------------------------------
module polled_point_table_tb;

    import ppt_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int TABLE_SLOTS     = 256;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_OFF_CYCLES = 1200;
    // The slowest correct run is about 2000 requests of a full table scan
    // each, plus stalls; the watchdog allows several times that.
    localparam int WATCHDOG_CYCLES = 3_000_000;

    // One result as it leaves the block.
    typedef struct packed {
        logic [ADDR_W-1:0]       address;
        logic signed [VAL_W-1:0] value;
        logic                    good;
        logic                    status;
    } t_point_reply;

    // Scoreboard: a shadow of the table plus the queue of results that the
    // accepted requests must still produce, oldest first.
    class t_point_table_shadow;
        logic [KEY_W-1:0]        slot_key[];
        logic signed [VAL_W-1:0] slot_value[];
        logic                    slot_good[];
        int unsigned             fill;
        int unsigned             capacity;
        t_point_reply            pending_replies[$];
        int unsigned             mismatch_count;

        function new(int unsigned slots);
            capacity       = slots;
            slot_key       = new[slots];
            slot_value     = new[slots];
            slot_good      = new[slots];
            fill           = 0;
            mismatch_count = 0;
        endfunction

        function logic [KEY_W-1:0] key_at(int unsigned idx);
            return slot_key[idx];
        endfunction

        // Applies one accepted request to the shadow table and queues the
        // result it must produce. Slots in use always form a prefix.
        function void note_request(logic [KIND_W-1:0] kind, logic [AREA_W-1:0] area,
                                   logic [ADDR_W-1:0] addr, logic signed [VAL_W-1:0] value);
            t_point_reply            reply;
            logic [KEY_W-1:0]        key;
            int                      hit;
            logic                    store_good;
            logic signed [VAL_W-1:0] store_value;

            key   = {area, addr};
            hit   = -1;
            reply = '{address: addr, value: '0, good: 1'b0, status: STATUS_OK};
            for (int i = 0; i < int'(fill); i++) begin
                if (slot_key[i] == key) begin
                    hit = i;
                    break;
                end
            end

            if (kind == KIND_RETRIEVE) begin
                if (hit >= 0) begin
                    reply.value = slot_value[hit];
                    reply.good  = slot_good[hit];
                end
            end else begin
                if (area == AREA_COIL || area == AREA_DISCRETE_INPUT) begin
                    store_good  = (value == 0 || value == 1);
                    store_value = store_good ? value : '0;
                end else begin
                    store_good  = (value != -1);
                    store_value = value;
                end
                if (hit >= 0) begin
                    slot_value[hit] = store_value;
                    slot_good[hit]  = store_good;
                    reply.good      = store_good;
                end else if (fill < capacity) begin
                    slot_key[fill]   = key;
                    slot_value[fill] = store_value;
                    slot_good[fill]  = store_good;
                    fill++;
                    reply.good = store_good;
                end else begin
                    reply.status = STATUS_OOM;
                end
            end
            pending_replies.push_back(reply);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_reply(logic [ADDR_W-1:0] addr, logic signed [VAL_W-1:0] value,
                         logic good, logic status);
            t_point_reply want;

            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result for address %h with none expected", addr));
                return;
            end
            want = pending_replies.pop_front();
            if (addr !== want.address)
                report_mismatch($sformatf("echo_address %h, expected %h", addr, want.address));
            if (value !== want.value)
                report_mismatch($sformatf("read_value %h, expected %h (address %h)",
                                          value, want.value, want.address));
            if (good !== want.good)
                report_mismatch($sformatf("point_good %b, expected %b (address %h)",
                                          good, want.good, want.address));
            if (status !== want.status)
                report_mismatch($sformatf("status %b, expected %b (address %h)",
                                          status, want.status, want.address));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [KIND_W-1:0]       i_kind;
    logic [AREA_W-1:0]       i_area;
    logic [ADDR_W-1:0]       i_point_address;
    logic signed [VAL_W-1:0] i_new_value;
    logic                    o_valid;
    logic                    i_stall;
    logic [ADDR_W-1:0]       o_echo_address;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_point_good;
    logic                    o_status;

    t_point_table_shadow shadow = new(TABLE_SLOTS);

    // Idling odds in percent per cycle, changed by the main sequence.
    int unsigned send_idle_pct  = 29;
    int unsigned recv_stall_pct = 49;
    // Raised by the main sequence to ask the result side for one long hold-off.
    bit          hold_off_pending = 1'b0;

    polled_point_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_area         (i_area),
        .i_point_address(i_point_address),
        .i_new_value    (i_new_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_echo_address (o_echo_address),
        .o_read_value   (o_read_value),
        .o_point_good   (o_point_good),
        .o_status       (o_status)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Offers one request and returns once it has been taken. It is called at
    // a falling edge and returns at a falling edge. Idle cycles come first,
    // so gaps land at any point of the block's scan. Each pass through the
    // idle loop sits in its own time step, so valid gets one assignment per
    // step.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [AREA_W-1:0] area,
                                input logic [ADDR_W-1:0] addr,
                                input logic signed [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_area          <= area;
        i_point_address <= addr;
        i_new_value     <= value;
        // Outputs are sampled at the rising edge, before the block updates.
        do @(posedge i_clk); while (o_stall);
        shadow.note_request(kind, area, addr, value);
        @(negedge i_clk);
    endtask

    // Values lean toward the ones the block treats specially: 0 and 1 for the
    // bit areas, all ones for the register areas, and the signed extremes.
    function automatic logic signed [VAL_W-1:0] random_point_value();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return 2;
            4:       return 32'sh8000_0000;
            5:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic. Most requests reuse keys already in the table so that
    // overwrites and hits are frequent; fresh keys fill the table until it is
    // full, after which they hit the out-of-memory path.
    task automatic send_random_requests(input int unsigned count);
        int unsigned       pick;
        logic [KIND_W-1:0] kind;
        logic [AREA_W-1:0] area;
        logic [ADDR_W-1:0] addr;

        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            kind = (pick < 65) ? KIND_UPDATE : KIND_RETRIEVE;
            area = $urandom_range(3);
            addr = $urandom_range(16'hFFFF);
            if ((pick < 35 || (pick >= 65 && pick < 90)) && shadow.fill > 0)
                {area, addr} = shadow.key_at($urandom_range(shadow.fill - 1));
            send_request(kind, area, addr, random_point_value());
        end
    endtask

    // Result side: owns i_stall. Besides the random stalls it performs the
    // long hold-off on request, counting the cycles itself, so the block's
    // output register fills and the request side backs up.
    initial begin : result_sink
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Every transfer on the result channel is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            shadow.check_reply(o_echo_address, o_read_value, o_point_good, o_status);
    end

    initial begin : main_sequence
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_kind          <= KIND_UPDATE;
        i_area          <= AREA_COIL;
        i_point_address <= '0;
        i_new_value     <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening. A retrieve on the empty table must miss.
        send_request(KIND_RETRIEVE, AREA_COIL, 16'h0000, 32'sh7FFF_FFFF);
        // Bit areas: 0 and 1 are good, anything else is stored as 0, not good.
        send_request(KIND_UPDATE, AREA_COIL, 16'h0000, 0);
        send_request(KIND_UPDATE, AREA_COIL, 16'hFFFF, 1);
        send_request(KIND_UPDATE, AREA_DISCRETE_INPUT, 16'h1234, 2);
        send_request(KIND_UPDATE, AREA_DISCRETE_INPUT, 16'h8000, -1);
        send_request(KIND_UPDATE, AREA_DISCRETE_INPUT, 16'h0001, 32'sh8000_0000);
        // Register areas: stored as given, not good only for all ones.
        send_request(KIND_UPDATE, AREA_INPUT_REG, 16'h0000, -1);
        send_request(KIND_UPDATE, AREA_INPUT_REG, 16'hFFFF, 32'sh7FFF_FFFF);
        send_request(KIND_UPDATE, AREA_HOLDING_REG, 16'hFFFF, 32'sh8000_0000);
        send_request(KIND_UPDATE, AREA_HOLDING_REG, 16'h00FF, 0);
        // Read everything back; the value on a retrieve is ignored.
        send_request(KIND_RETRIEVE, AREA_COIL, 16'h0000, -1);
        send_request(KIND_RETRIEVE, AREA_COIL, 16'hFFFF, 0);
        send_request(KIND_RETRIEVE, AREA_DISCRETE_INPUT, 16'h1234, 1);
        send_request(KIND_RETRIEVE, AREA_DISCRETE_INPUT, 16'h8000, 0);
        send_request(KIND_RETRIEVE, AREA_INPUT_REG, 16'h0000, 0);
        send_request(KIND_RETRIEVE, AREA_INPUT_REG, 16'hFFFF, 0);
        send_request(KIND_RETRIEVE, AREA_HOLDING_REG, 16'hFFFF, 0);
        // Same address in an area where it was never stored must miss.
        send_request(KIND_RETRIEVE, AREA_HOLDING_REG, 16'h0000, 0);
        // Overwrite existing entries, flipping the good mark both ways.
        send_request(KIND_UPDATE, AREA_COIL, 16'h0000, 5);
        send_request(KIND_RETRIEVE, AREA_COIL, 16'h0000, 0);
        send_request(KIND_UPDATE, AREA_HOLDING_REG, 16'h00FF, -1);
        send_request(KIND_RETRIEVE, AREA_HOLDING_REG, 16'h00FF, 0);
        send_request(KIND_UPDATE, AREA_INPUT_REG, 16'h0000, 32'sh1234_5678);
        send_request(KIND_RETRIEVE, AREA_INPUT_REG, 16'h0000, 0);

        // Random traffic; the table fills up during the first phases.
        send_random_requests(667);
        send_idle_pct  = 49;
        recv_stall_pct = 29;
        send_random_requests(667);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_pending = 1'b1;
        send_random_requests(666);
        i_valid <= 1'b0;

        // Drain, then allow one more full scan for any stray result.
        while (shadow.pending_replies.size() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 20) @(posedge i_clk);
        if (shadow.mismatch_count == 0) begin
            $display("polled_point_table verification clean");
        end else begin
            $display("polled_point_table verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("polled_point_table verification failed");
        $finish;
    end

endmodule
